>>> hdl/cbe_pkg.sv
// ----------------------------------------------------------------------------
// cbe_pkg
// shared types and constants for the cbor item encoder
// ----------------------------------------------------------------------------
package cbe_pkg;

  localparam int KIND_W  = 4;
  localparam int VALUE_W = 64;
  localparam int BYTE_W  = 8;
  localparam int CNT_W   = 4;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [KIND_W-1:0] KIND_UINT    = 4'd0;
  localparam logic [KIND_W-1:0] KIND_SINT    = 4'd1;
  localparam logic [KIND_W-1:0] KIND_BYTES   = 4'd2;
  localparam logic [KIND_W-1:0] KIND_TEXT    = 4'd3;
  localparam logic [KIND_W-1:0] KIND_ARRAY   = 4'd4;
  localparam logic [KIND_W-1:0] KIND_MAP     = 4'd5;
  localparam logic [KIND_W-1:0] KIND_TAG     = 4'd6;
  localparam logic [KIND_W-1:0] KIND_SIMPLE  = 4'd7;
  localparam logic [KIND_W-1:0] KIND_F32     = 4'd8;
  localparam logic [KIND_W-1:0] KIND_F64     = 4'd9;
  localparam logic [KIND_W-1:0] KIND_BOOL    = 4'd10;
  localparam logic [KIND_W-1:0] KIND_NULL    = 4'd11;
  localparam logic [KIND_W-1:0] KIND_UNDEF   = 4'd12;
  localparam logic [KIND_W-1:0] KIND_PAYLOAD = 4'd13;

  localparam logic [2:0] MT_UINT   = 3'd0;
  localparam logic [2:0] MT_NINT   = 3'd1;
  localparam logic [2:0] MT_SIMPLE = 3'd7;

  localparam logic [4:0] AI_ONE   = 5'd24;
  localparam logic [4:0] AI_TWO   = 5'd25;
  localparam logic [4:0] AI_FOUR  = 5'd26;
  localparam logic [4:0] AI_EIGHT = 5'd27;

  localparam logic [BYTE_W-1:0] BYTE_FALSE = 8'hf4;
  localparam logic [BYTE_W-1:0] BYTE_TRUE  = 8'hf5;
  localparam logic [BYTE_W-1:0] BYTE_NULL  = 8'hf6;
  localparam logic [BYTE_W-1:0] BYTE_UNDEF = 8'hf7;
  localparam logic [BYTE_W-1:0] BYTE_F32   = 8'hfa;
  localparam logic [BYTE_W-1:0] BYTE_F64   = 8'hfb;

  // one classified item: head byte, argument byte count, argument left-aligned
  typedef struct packed {
    logic [BYTE_W-1:0]  head;
    logic [CNT_W-1:0]   n_arg;
    logic [VALUE_W-1:0] arg;
  } cbe_desc_t;

endpackage

>>> hdl/cbe_if.sv
// ----------------------------------------------------------------------------
// cbe_if
// valid/ready channels for data items in and encoded bytes out
// ----------------------------------------------------------------------------
interface cbe_in_if;
  logic                         valid;
  logic                         ready;
  logic [cbe_pkg::KIND_W-1:0]   item_kind;
  logic [cbe_pkg::VALUE_W-1:0]  item_value;

  modport source (output valid, output item_kind, output item_value, input ready);
  modport sink   (input valid, input item_kind, input item_value, output ready);
endinterface

interface cbe_out_if;
  logic                        valid;
  logic                        ready;
  logic [cbe_pkg::BYTE_W-1:0]  out_byte;
  logic                        last_byte;

  modport source (output valid, output out_byte, output last_byte, input ready);
  modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

>>> hdl/cbe_front.sv
// ----------------------------------------------------------------------------
// cbe_front
// accepts data items and classifies them into head byte and argument bytes
// ----------------------------------------------------------------------------
module cbe_front (
  cbe_in_if.sink            in_chan,
  input  logic              q_full,
  output logic              q_wr,
  output cbe_pkg::cbe_desc_t q_wr_data
);
  import cbe_pkg::*;

  logic [VALUE_W-1:0] v;
  logic [2:0]         mt;
  logic               use_head;
  logic               known;
  cbe_desc_t          fixed;
  cbe_desc_t          headed;

  always_comb begin
    v        = in_chan.item_value;
    mt       = MT_UINT;
    use_head = 1'b1;
    known    = 1'b1;
    fixed    = '0;
    unique case (in_chan.item_kind)
      KIND_UINT: begin
        mt = MT_UINT;
      end
      KIND_SINT: begin
        if (in_chan.item_value[VALUE_W-1]) begin
          mt = MT_NINT;
          v  = ~in_chan.item_value;
        end
      end
      KIND_BYTES, KIND_TEXT, KIND_ARRAY, KIND_MAP, KIND_TAG: begin
        mt = in_chan.item_kind[2:0];
      end
      KIND_SIMPLE: begin
        mt = MT_SIMPLE;
        v  = {{(VALUE_W-BYTE_W){1'b0}}, in_chan.item_value[BYTE_W-1:0]};
      end
      KIND_F32: begin
        use_head    = 1'b0;
        fixed.head  = BYTE_F32;
        fixed.n_arg = CNT_W'(4);
        fixed.arg   = {in_chan.item_value[31:0], 32'd0};
      end
      KIND_F64: begin
        use_head    = 1'b0;
        fixed.head  = BYTE_F64;
        fixed.n_arg = CNT_W'(8);
        fixed.arg   = in_chan.item_value;
      end
      KIND_BOOL: begin
        use_head   = 1'b0;
        fixed.head = in_chan.item_value[0] ? BYTE_TRUE : BYTE_FALSE;
      end
      KIND_NULL: begin
        use_head   = 1'b0;
        fixed.head = BYTE_NULL;
      end
      KIND_UNDEF: begin
        use_head   = 1'b0;
        fixed.head = BYTE_UNDEF;
      end
      KIND_PAYLOAD: begin
        use_head   = 1'b0;
        fixed.head = in_chan.item_value[BYTE_W-1:0];
      end
      default: begin
        use_head = 1'b0;
        known    = 1'b0;
      end
    endcase
  end

  // argument size selection
  always_comb begin
    headed = '0;
    priority if (v[63:32] != 32'd0) begin
      headed.head  = {mt, AI_EIGHT};
      headed.n_arg = CNT_W'(8);
      headed.arg   = v;
    end else if (v[31:16] != 16'd0) begin
      headed.head  = {mt, AI_FOUR};
      headed.n_arg = CNT_W'(4);
      headed.arg   = {v[31:0], 32'd0};
    end else if (v[15:8] != 8'd0) begin
      headed.head  = {mt, AI_TWO};
      headed.n_arg = CNT_W'(2);
      headed.arg   = {v[15:0], 48'd0};
    end else if (v[7:0] >= 8'd24) begin
      headed.head  = {mt, AI_ONE};
      headed.n_arg = CNT_W'(1);
      headed.arg   = {v[7:0], 56'd0};
    end else begin
      headed.head  = {mt, v[4:0]};
    end
  end

  assign in_chan.ready = !q_full;
  assign q_wr          = in_chan.valid && !q_full && known;
  assign q_wr_data     = use_head ? headed : fixed;

endmodule

>>> hdl/cbe_queue.sv
// ----------------------------------------------------------------------------
// cbe_queue
// short first-in first-out queue of classified items
// ----------------------------------------------------------------------------
module cbe_queue #(
  parameter int DEPTH = cbe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr,
  input  cbe_pkg::cbe_desc_t wr_data,
  input  logic               rd,
  output cbe_pkg::cbe_desc_t rd_data,
  output logic               full,
  output logic               empty
);
  import cbe_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);

  cbe_desc_t          mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0]  count_r, count_nxt;
  logic               do_wr, do_rd;

  assign full  = (count_r == CNT_QW'(DEPTH));
  assign empty = (count_r == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> hdl/cbe_back.sv
// ----------------------------------------------------------------------------
// cbe_back
// serializes classified items into bytes through a registered output stage
// ----------------------------------------------------------------------------
module cbe_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  cbe_pkg::cbe_desc_t q_rd_data,
  output logic               q_rd,
  cbe_out_if.source          out_chan
);
  import cbe_pkg::*;

  logic               out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]  out_byte_r, out_byte_nxt;
  logic               out_last_r, out_last_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [VALUE_W-1:0] arg_r, arg_nxt;
  logic               advance;

  assign advance = !out_valid_r || out_chan.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    cnt_nxt       = cnt_r;
    arg_nxt       = arg_r;
    q_rd          = 1'b0;
    if (advance) begin
      if (cnt_r != '0) begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = arg_r[VALUE_W-1 -: BYTE_W];
        out_last_nxt  = (cnt_r == CNT_W'(1));
        arg_nxt       = {arg_r[VALUE_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
        cnt_nxt       = cnt_r - 1'b1;
      end else if (!q_empty) begin
        q_rd          = 1'b1;
        out_valid_nxt = 1'b1;
        out_byte_nxt  = q_rd_data.head;
        out_last_nxt  = (q_rd_data.n_arg == '0);
        arg_nxt       = q_rd_data.arg;
        cnt_nxt       = q_rd_data.n_arg;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    arg_r      <= arg_nxt;
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.out_byte  = out_byte_r;
  assign out_chan.last_byte = out_last_r;

endmodule

>>> hdl/cbor_item_encoder_top.sv
// ----------------------------------------------------------------------------
// cbor_item_encoder_top
// cbor data item encoder: one item in, its encoded bytes out
// ----------------------------------------------------------------------------
// in_chan takes one item per handshake: a kind code and a 64-bit value.
// out_chan gives the encoded stream one byte per handshake, with last_byte
// set on the final byte of each item. unused kind codes are accepted and
// produce no bytes.
// an item gives one head byte plus 0, 1, 2, 4 or 8 argument bytes, chosen
// in the front end. with the queue empty, an accepted item goes into the
// queue and its head byte then loads the output register. items are
// accepted every cycle while the queue has room, so the sustained input
// rate equals the output byte rate divided by the byte count per item;
// single-byte items stream at one per cycle while the receiver is ready.
// when the receiver stalls, the output register holds its byte, the queue
// fills and in_chan.ready drops once QUEUE_DEPTH items are waiting.
// reset empties the queue and the output register; no bytes are pending.
// ----------------------------------------------------------------------------
module cbor_item_encoder_top #(
  parameter int QUEUE_DEPTH = cbe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  cbe_in_if.sink     in_chan,
  cbe_out_if.source  out_chan
);
  import cbe_pkg::*;

  logic      q_wr;
  cbe_desc_t q_wr_data;
  logic      q_rd;
  cbe_desc_t q_rd_data;
  logic      q_full;
  logic      q_empty;

  cbe_front u_front (
    .in_chan   (in_chan),
    .q_full    (q_full),
    .q_wr      (q_wr),
    .q_wr_data (q_wr_data)
  );

  cbe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .wr_data (q_wr_data),
    .rd      (q_rd),
    .rd_data (q_rd_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  cbe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_rd_data (q_rd_data),
    .q_rd      (q_rd),
    .out_chan  (out_chan)
  );

endmodule

>>> tb/sv/tb_cbor_item_encoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cbor_item_encoder_top
// self-checking bench for the cbor data item encoder
// ----------------------------------------------------------------------------
// a directed table walks the head size boundaries, every kind code, the
// negative integer, simple, float, bool and unused kind cases, then random
// items (and short string runs) follow. each accepted item gets the run it
// should produce, from its table row or a local model, and every output
// byte is checked in order against it, data and end-of-item flag. both
// channels idle and stall in random bursts, except in the closing stretch.
// ----------------------------------------------------------------------------
module tb_cbor_item_encoder_top;
  import cbe_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 4'd14;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 4'd15;

  localparam logic [VALUE_W-1:0] LIMIT_INLINE = 64'd24;
  localparam logic [VALUE_W-1:0] LIMIT_ONE    = 64'd256;
  localparam logic [VALUE_W-1:0] LIMIT_TWO    = 64'd65536;
  localparam logic [VALUE_W-1:0] LIMIT_FOUR   = 64'h1_0000_0000;

  localparam int PREDICTED     = -1;
  localparam int RANDOM_ITEMS  = 70;
  localparam int CALM_ITEMS    = 20;
  localparam int SETTLE_CYCLES = 16;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    int                 gold_n;
    logic [71:0]        gold;
  } stim_row_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } enc_byte_t;

  logic clk = 1'b0;
  logic rst_n;
  bit   idle_on = 1'b1;

  stim_row_t directed_rows[$];
  enc_byte_t pending_bytes[$];
  int error_count = 0;
  int items_sent  = 0;
  int spare_sent  = 0;
  int bytes_seen  = 0;

  cbe_in_if  item_in ();
  cbe_out_if byte_out ();

  cbor_item_encoder_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (item_in),
    .out_chan (byte_out)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch at %0t: %s got %02h expected %02h", $time, what, got, want);
    error_count++;
  endtask

  // shifts nb bytes of v, most significant first, onto the encoded run
  function automatic void append_be(inout int n, inout logic [71:0] run,
                                    input logic [63:0] v, input int nb);
    for (int i = nb - 1; i >= 0; i--) begin
      run = {run[63:0], v[8*i +: 8]};
      n++;
    end
  endfunction

  function automatic void append_head(inout int n, inout logic [71:0] run,
                                      input logic [2:0] major, input logic [63:0] arg);
    if (arg < LIMIT_INLINE) begin
      append_be(n, run, {major, arg[4:0]}, 1);
    end else if (arg < LIMIT_ONE) begin
      append_be(n, run, {major, AI_ONE}, 1);
      append_be(n, run, arg, 1);
    end else if (arg < LIMIT_TWO) begin
      append_be(n, run, {major, AI_TWO}, 1);
      append_be(n, run, arg, 2);
    end else if (arg < LIMIT_FOUR) begin
      append_be(n, run, {major, AI_FOUR}, 1);
      append_be(n, run, arg, 4);
    end else begin
      append_be(n, run, {major, AI_EIGHT}, 1);
      append_be(n, run, arg, 8);
    end
  endfunction

  // byte run for one item, first byte in the highest used byte of run
  function automatic int encode_item(input logic [KIND_W-1:0] kind,
                                     input logic [VALUE_W-1:0] value,
                                     output logic [71:0] run);
    int n;
    n = 0;
    run = '0;
    case (kind)
      KIND_UINT: append_head(n, run, MT_UINT, value);
      KIND_SINT: begin
        if (value[63]) append_head(n, run, MT_NINT, ~value);
        else append_head(n, run, MT_UINT, value);
      end
      KIND_BYTES, KIND_TEXT, KIND_ARRAY, KIND_MAP, KIND_TAG:
        append_head(n, run, kind[2:0], value);
      KIND_SIMPLE: append_head(n, run, MT_SIMPLE, {56'd0, value[7:0]});
      KIND_F32: begin
        append_be(n, run, BYTE_F32, 1);
        append_be(n, run, {32'd0, value[31:0]}, 4);
      end
      KIND_F64: begin
        append_be(n, run, BYTE_F64, 1);
        append_be(n, run, value, 8);
      end
      KIND_BOOL:    append_be(n, run, value[0] ? BYTE_TRUE : BYTE_FALSE, 1);
      KIND_NULL:    append_be(n, run, BYTE_NULL, 1);
      KIND_UNDEF:   append_be(n, run, BYTE_UNDEF, 1);
      KIND_PAYLOAD: append_be(n, run, value, 1);
      default: ;
    endcase
    return n;
  endfunction

  // argument spread evenly over the five head sizes
  function automatic logic [63:0] pick_argument();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0: r = r % LIMIT_INLINE;
      1: r = LIMIT_INLINE + r % (LIMIT_ONE - LIMIT_INLINE);
      2: r = LIMIT_ONE + r % (LIMIT_TWO - LIMIT_ONE);
      3: r = LIMIT_TWO + r % (LIMIT_FOUR - LIMIT_TWO);
      default: r = r | LIMIT_FOUR;
    endcase
    return r;
  endfunction

  function automatic void add_row(input logic [KIND_W-1:0] kind, input logic [63:0] value,
                                  input int gold_n, input logic [71:0] gold);
    directed_rows.push_back({kind, value, gold_n, gold});
  endfunction

  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] value,
                           input int gold_n, input logic [71:0] gold);
    logic [71:0] run;
    int n;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      item_in.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    item_in.valid      <= 1'b1;
    item_in.item_kind  <= kind;
    item_in.item_value <= value;
    @(posedge clk);
    while (!item_in.ready) @(posedge clk);
    if (gold_n == PREDICTED) begin
      n = encode_item(kind, value, run);
    end else begin
      n = gold_n;
      run = gold;
    end
    for (int i = n - 1; i >= 0; i--) pending_bytes.push_back({run[8*i +: 8], i == 0});
    if (kind > KIND_PAYLOAD) spare_sent++;
    items_sent++;
  endtask

  // hold the input off until the output has caught up
  task automatic wait_drained();
    item_in.valid <= 1'b0;
    do @(posedge clk); while (pending_bytes.size() != 0);
  endtask

  // receiver: checks accepted bytes and stalls in bursts
  initial begin
    int stall_left;
    enc_byte_t want;
    stall_left = 0;
    byte_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && byte_out.valid && byte_out.ready) begin
        bytes_seen++;
        if (pending_bytes.size() == 0) begin
          report_mismatch("byte with nothing pending", byte_out.out_byte, 8'h00);
        end else begin
          want = pending_bytes.pop_front();
          if (byte_out.out_byte !== want.data)
            report_mismatch("out_byte", byte_out.out_byte, want.data);
          if (byte_out.last_byte !== want.last)
            report_mismatch("last_byte", {7'd0, byte_out.last_byte}, {7'd0, want.last});
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        byte_out.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        byte_out.ready <= 1'b0;
      end else begin
        byte_out.ready <= 1'b1;
      end
    end
  end

  initial begin
    int sent;
    int len;
    bit paused;
    logic [KIND_W-1:0] kind;
    logic [VALUE_W-1:0] value;
    logic [VALUE_W-1:0] arg;
    sent = 0;
    paused = 1'b0;
    rst_n              <= 1'b0;
    item_in.valid      <= 1'b0;
    item_in.item_kind  <= KIND_NULL;
    item_in.item_value <= '0;

    // head size boundaries
    add_row(KIND_UINT, 64'd0, 1, 72'h00);
    add_row(KIND_UINT, 64'd23, 1, 72'h17);
    add_row(KIND_UINT, 64'd24, 2, 72'h1818);
    add_row(KIND_UINT, 64'd255, 2, 72'h18ff);
    add_row(KIND_UINT, 64'd256, 3, 72'h190100);
    add_row(KIND_UINT, 64'd65536, 5, 72'h1a00010000);
    add_row(KIND_UINT, 64'h1_0000_0000, 9, 72'h1b0000000100000000);
    add_row(KIND_UINT, '1, 9, 72'h1bffffffffffffffff);
    // negative integers go out as major type 1 with the complement
    add_row(KIND_SINT, '1, 1, 72'h20);
    add_row(KIND_SINT, -64'sd25, 2, 72'h3818);
    add_row(KIND_SINT, 64'h8000_0000_0000_0000, 9, 72'h3b7fffffffffffffff);
    add_row(KIND_SINT, 64'd1000, PREDICTED, '0);
    add_row(KIND_BYTES, 64'd5, 1, 72'h45);
    add_row(KIND_TEXT, 64'd1000, PREDICTED, '0);
    add_row(KIND_ARRAY, 64'd0, 1, 72'h80);
    add_row(KIND_MAP, 64'd70000, PREDICTED, '0);
    add_row(KIND_TAG, '1, PREDICTED, '0);
    // simple uses only the low byte
    add_row(KIND_SIMPLE, 64'hffff_ffff_ffff_ff18, 2, 72'hf818);
    add_row(KIND_F32, 64'hdead_beef_3f80_0000, 5, 72'hfa3f800000);
    add_row(KIND_F64, 64'h3ff0_0000_0000_0000, 9, 72'hfb3ff0000000000000);
    add_row(KIND_BOOL, 64'hffff_ffff_ffff_fffe, 1, 72'hf4);
    add_row(KIND_BOOL, 64'd1, 1, 72'hf5);
    add_row(KIND_NULL, '1, 1, 72'hf6);
    add_row(KIND_UNDEF, 64'd0, 1, 72'hf7);
    add_row(KIND_PAYLOAD, 64'h1234_5678_9abc_deab, 1, 72'hab);
    add_row(KIND_SPARE_LO, '1, 0, '0);
    add_row(KIND_SPARE_HI, 64'd0, 0, '0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_item(directed_rows[i].kind, directed_rows[i].value,
                directed_rows[i].gold_n, directed_rows[i].gold);
    wait_drained();

    while (sent < RANDOM_ITEMS) begin
      if (sent >= RANDOM_ITEMS - CALM_ITEMS) idle_on <= 1'b0;
      if (!paused && sent >= RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        wait_drained();
      end
      if ($urandom_range(0, 9) == 0) begin
        // string header followed by its payload bytes
        len = $urandom_range(0, 6);
        send_item($urandom_range(0, 1) ? KIND_TEXT : KIND_BYTES, VALUE_W'(len),
                  PREDICTED, '0);
        repeat (len) send_item(KIND_PAYLOAD, {$urandom, $urandom}, PREDICTED, '0);
        sent += len + 1;
      end else begin
        kind = KIND_W'($urandom_range(KIND_UINT, KIND_SPARE_HI));
        case (kind)
          KIND_SINT: begin
            arg = pick_argument();
            arg[63] = 1'b0;
            value = $urandom_range(0, 1) ? ~arg : arg;
          end
          KIND_SIMPLE: begin
            value = {$urandom, $urandom};
            if ($urandom_range(0, 1)) value[7:0] = 8'($urandom_range(0, 23));
          end
          KIND_F32, KIND_F64, KIND_BOOL, KIND_NULL, KIND_UNDEF, KIND_PAYLOAD,
          KIND_SPARE_LO, KIND_SPARE_HI:
            value = {$urandom, $urandom};
          default: value = pick_argument();
        endcase
        send_item(kind, value, PREDICTED, '0);
        if (kind <= KIND_PAYLOAD) sent++;
      end
    end

    item_in.valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("summary: %0d items sent (%0d directed, %0d unused kinds), %0d bytes checked",
             items_sent, directed_rows.size(), spare_sent, bytes_seen);
    $display("summary: all head sizes, every kind, string runs, stalls on both sides");
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/cbe_pkg.sv
hdl/cbe_if.sv
hdl/cbe_front.sv
hdl/cbe_queue.sv
hdl/cbe_back.sv
hdl/cbor_item_encoder_top.sv
tb/sv/tb_cbor_item_encoder_top.sv
